/* rtl/ipcsum_pkg.sv */
package ipcsum_pkg;

    localparam logic [15:0] WORD_MAX      = 16'hffff;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [15:0] EARLY_BYTES   = 16'd4;
    localparam logic [13:0] FRAG_ZERO     = 14'd0;

    // fixed byte offsets inside the ipv4 header
    localparam logic [15:0] IDX_IHL        = 16'd0;
    localparam logic [15:0] IDX_TLEN_HI    = 16'd2;
    localparam logic [15:0] IDX_TLEN_LO    = 16'd3;
    localparam logic [15:0] IDX_FRAG_HI    = 16'd6;
    localparam logic [15:0] IDX_FRAG_LO    = 16'd7;
    localparam logic [15:0] IDX_PROTO      = 16'd9;
    localparam logic [15:0] IDX_ADDR_FIRST = 16'd12;
    localparam logic [15:0] IDX_ADDR_END   = 16'd20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } ipcsum_item_t;

    // packet state frozen at the last byte
    typedef struct packed {
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [15:0] fragment_field;
        logic [15:0] header_sum;
        logic [15:0] segment_sum;
        logic [15:0] byte_offset;
    } ipcsum_snap_t;

    typedef struct packed {
        logic ip_header_ok;
        logic tcp_ok;
        logic fragmented;
        logic length_error;
    } ipcsum_result_t;

    // ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

/* rtl/ipcsum_accum.sv */
module ipcsum_accum
    import ipcsum_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_en,
    input  ipcsum_item_t item,
    input  logic         snap_take,
    output logic         snap_valid,
    output ipcsum_snap_t snap
);

    logic [15:0]  off_reg, off_next, off_cur, off_upd;
    logic [3:0]   hw_reg, hw_next, hw_cur, hw_upd;
    logic [15:0]  tl_reg, tl_next, tl_cur, tl_upd;
    logic [15:0]  ff_reg, ff_next, ff_cur, ff_upd;
    logic [15:0]  hs_reg, hs_next, hs_cur, hs_upd;
    logic [15:0]  ss_reg, ss_next, ss_cur, ss_upd;
    logic [15:0]  part;
    logic [15:0]  hbytes;
    logic [15:0]  seg_a;
    logic         in_total;
    logic         pseudo;
    logic         snap_valid_reg, snap_valid_next;
    ipcsum_snap_t snap_reg, snap_next;

    always_comb
    begin
        // first byte restarts from the cleared state
        off_cur = item.first_byte ? 16'd0 : off_reg;
        hw_cur  = item.first_byte ? 4'd0  : hw_reg;
        tl_cur  = item.first_byte ? 16'd0 : tl_reg;
        ff_cur  = item.first_byte ? 16'd0 : ff_reg;
        hs_cur  = item.first_byte ? 16'd0 : hs_reg;
        ss_cur  = item.first_byte ? 16'd0 : ss_reg;

        part = off_cur[0] ? {8'h00, item.data_byte} : {item.data_byte, 8'h00};

        hw_upd = hw_cur;
        tl_upd = tl_cur;
        ff_upd = ff_cur;
        if (off_cur == IDX_IHL)
        begin
            hw_upd = item.data_byte[3:0];
        end
        if (off_cur == IDX_TLEN_HI)
        begin
            tl_upd = {item.data_byte, tl_cur[7:0]};
        end
        if (off_cur == IDX_TLEN_LO)
        begin
            tl_upd = {tl_cur[15:8], item.data_byte};
        end
        if (off_cur == IDX_FRAG_HI)
        begin
            ff_upd = {item.data_byte, ff_cur[7:0]};
        end
        if (off_cur == IDX_FRAG_LO)
        begin
            ff_upd = {ff_cur[15:8], item.data_byte};
        end

        hbytes   = {10'd0, hw_upd, 2'b00};
        in_total = (off_cur < EARLY_BYTES) || (off_cur < tl_upd);
        pseudo   = (off_cur == IDX_PROTO) ||
                   ((off_cur >= IDX_ADDR_FIRST) && (off_cur < IDX_ADDR_END));

        hs_upd = (off_cur < hbytes) ? oc_add(hs_cur, part) : hs_cur;
        seg_a  = ((off_cur >= hbytes) && in_total) ? oc_add(ss_cur, part) : ss_cur;
        ss_upd = pseudo ? oc_add(seg_a, part) : seg_a;
        off_upd = off_cur + 16'd1;

        // saturated offset: byte ignored
        if (off_cur == WORD_MAX)
        begin
            hw_upd  = hw_cur;
            tl_upd  = tl_cur;
            ff_upd  = ff_cur;
            hs_upd  = hs_cur;
            ss_upd  = ss_cur;
            off_upd = off_cur;
        end

        off_next = off_reg;
        hw_next  = hw_reg;
        tl_next  = tl_reg;
        ff_next  = ff_reg;
        hs_next  = hs_reg;
        ss_next  = ss_reg;
        if (item_en)
        begin
            if (item.last_byte)
            begin
                off_next = 16'd0;
                hw_next  = 4'd0;
                tl_next  = 16'd0;
                ff_next  = 16'd0;
                hs_next  = 16'd0;
                ss_next  = 16'd0;
            end
            else
            begin
                off_next = off_upd;
                hw_next  = hw_upd;
                tl_next  = tl_upd;
                ff_next  = ff_upd;
                hs_next  = hs_upd;
                ss_next  = ss_upd;
            end
        end

        snap_next.header_words   = hw_upd;
        snap_next.total_length   = tl_upd;
        snap_next.fragment_field = ff_upd;
        snap_next.header_sum     = hs_upd;
        snap_next.segment_sum    = ss_upd;
        snap_next.byte_offset    = off_upd;

        snap_valid_next = snap_valid_reg && !snap_take;
        if (item_en && item.last_byte)
        begin
            snap_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg        <= 16'd0;
            hw_reg         <= 4'd0;
            tl_reg         <= 16'd0;
            ff_reg         <= 16'd0;
            hs_reg         <= 16'd0;
            ss_reg         <= 16'd0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            off_reg        <= off_next;
            hw_reg         <= hw_next;
            tl_reg         <= tl_next;
            ff_reg         <= ff_next;
            hs_reg         <= hs_next;
            ss_reg         <= ss_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_en && item.last_byte)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

/* rtl/ipcsum_check.sv */
module ipcsum_check
    import ipcsum_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           snap_take,
    input  ipcsum_snap_t   snap,
    input  logic           out_stall,
    output logic           out_valid,
    output ipcsum_result_t result
);

    logic [15:0]    hbytes;
    logic [15:0]    tcp_len;
    logic [15:0]    tsum;
    logic           frag;
    logic           lerr;
    ipcsum_result_t result_reg, result_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        hbytes  = {10'd0, snap.header_words, 2'b00};
        tcp_len = snap.total_length - hbytes;
        tsum    = oc_add(snap.segment_sum, tcp_len);
        frag    = snap.fragment_field[13:0] != FRAG_ZERO;
        lerr    = (snap.total_length < MIN_HDR_BYTES) || (snap.total_length < hbytes) ||
                  (snap.byte_offset < snap.total_length) ||
                  (snap.byte_offset < MIN_HDR_BYTES);

        result_next.ip_header_ok = (snap.header_sum == 16'd0) || (snap.header_sum == WORD_MAX);
        result_next.tcp_ok       = !lerr && (frag || (tsum == WORD_MAX));
        result_next.fragmented   = frag;
        result_next.length_error = lerr;

        out_valid_next = out_valid_reg && out_stall;
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

/* rtl/ipv4_tcp_checksum_verifier.sv */
// a result reaches out_valid from its last byte through the input word, snapshot and output registers
// throughput: one packet byte per cycle except during the stall below; set by the sum update
// bytes keep flowing while a result waits; input stalls only when a packet end
// arrives while one result sits in the snapshot register and another is held at the output
// reset: asynchronous, active low; clears the running sums, counters and valid flags
module ipv4_tcp_checksum_verifier
    import ipcsum_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ip_header_ok,
    output logic       tcp_ok,
    output logic       fragmented,
    output logic       length_error
);

    // input word register
    ipcsum_item_t   s1_reg, s1_next;
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_adv;
    logic           item_en;

    // frozen packet state and handoff to the check stage
    logic           snap_valid;
    ipcsum_snap_t   snap;
    logic           snap_take;
    ipcsum_result_t result;

    // the output register takes a snapshot when empty or being drained
    assign snap_take = snap_valid && (!out_valid || !out_stall);

    // a non-last word never produces a result, so it always moves on;
    // a last word needs the snapshot stage free or emptying this cycle
    assign s1_adv   = !s1_reg.last_byte || !snap_valid || snap_take;
    assign item_en  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (!in_stall)
        begin
            s1_valid_next        = in_valid;
            s1_next.data_byte    = data_byte;
            s1_next.first_byte   = first_byte;
            s1_next.last_byte    = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // running sums and header field capture
    ipcsum_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (item_en),
        .item       (s1_reg),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    // final fold, length checks and output register
    ipcsum_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap_take (snap_take),
        .snap      (snap),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .result    (result)
    );

    assign ip_header_ok = result.ip_header_ok;
    assign tcp_ok       = result.tcp_ok;
    assign fragmented   = result.fragmented;
    assign length_error = result.length_error;

`ifndef SYNTHESIS
    // input only backs up behind a held snapshot
    a_stall_needs_snap: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (snap_valid && s1_reg.last_byte))
        else $error("input stalled without a pending snapshot");

    // a drained output with nothing behind it goes empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !snap_valid) |=> !out_valid)
        else $error("output valid persisted without new result");

    // a taken snapshot always shows at the output next cycle
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        snap_take |=> out_valid)
        else $error("snapshot lost between stages");

    // a length error never passes the tcp check
    a_lerr_blocks_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && length_error) |-> !tcp_ok)
        else $error("tcp_ok set with length error");
`endif

endmodule
